### hdl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Types, character codes and digit helpers shared by the literal scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int DATA_W          = 64;
    localparam int USER_W          = 4;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_ZERO    = 2'd1,
        PH_DIGITS  = 2'd2,
        PH_SWALLOW = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_BIN = 2'd2,
        RX_OCT = 2'd3
    } radix_t;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_UX = 8'h58;
    localparam logic [7:0] CH_LB = 8'h62;
    localparam logic [7:0] CH_UB = 8'h42;

    localparam logic [4:0] NO_DIGIT = 5'd16;

    // One result item as it leaves the scanner core.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        radix_t            radix;
        logic              bad_digit;
        logic              overflow;
    } res_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if ((c >= CH_0) && (c <= CH_9)) d = c - CH_0;
        else if ((c >= CH_LA) && (c <= CH_LF)) d = c - CH_LA + 8'd10;
        else if ((c >= CH_UA) && (c <= CH_UF)) d = c - CH_UA + 8'd10;
        else d = {3'b000, NO_DIGIT};
        return d[4:0];
    endfunction

    function automatic logic [4:0] base_of(input radix_t rc);
        logic [4:0] b;
        case (rc)
            RX_HEX:  b = 5'd16;
            RX_BIN:  b = 5'd2;
            RX_OCT:  b = 5'd8;
            default: b = 5'd10;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### hdl/ils_in_reg.sv
// ----------------------------------------------------------------------------
// ils_in_reg
// Input register: captures one character item and holds it until the core
// consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] ch
    input  wire logic       consume,
    output logic            ch_valid,
    output logic [7:0]      ch
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;

    assign s_tready = !valid_reg || consume;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
            valid_next = 1'b1;
        else if (consume)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            ch_reg <= s_tdata;
    end

    assign ch_valid = valid_reg;
    assign ch       = ch_reg;

endmodule

`default_nettype wire

### hdl/ils_core.sv
// ----------------------------------------------------------------------------
// ils_core
// Scanner state and per-character next-state logic: prefix detection,
// shift-and-add accumulation, bad-digit and overflow tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_core #(
    parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] ch,
    input  wire logic       advance,
    output logic            emit,
    output ils_pkg::res_t   res
);

    localparam int XW = VALUE_WIDTH + 5;

    ils_pkg::phase_t        phase_reg,  phase_next;
    ils_pkg::radix_t        radix_reg,  radix_next;
    logic [VALUE_WIDTH-1:0] accum_reg,  accum_next;
    logic                   bad_reg,    bad_next;

    ils_pkg::radix_t rad_eff;
    logic [4:0]      base;
    logic [4:0]      dig;
    logic            dig_bad;
    logic [3:0]      dig_eff;
    logic            bad_take;
    logic [XW-1:0]   acc_x;
    logic [XW-1:0]   prod;
    logic [XW-1:0]   sum;
    logic            ovf;
    logic            ch_dec;
    logic            ovf_out;

    assign ch_dec  = ils_pkg::is_dec(ch);
    // A decimal digit right after the leading zero switches to octal.
    assign rad_eff = ((phase_reg == ils_pkg::PH_ZERO) && ch_dec) ? ils_pkg::RX_OCT
                                                                 : radix_reg;
    assign base    = ils_pkg::base_of(rad_eff);
    assign dig     = ils_pkg::hex_value(ch);
    assign dig_bad = (dig != ils_pkg::NO_DIGIT) && (dig >= base);
    assign dig_eff = dig_bad ? 4'd0 : dig[3:0];
    assign bad_take = bad_reg || dig_bad;

    assign acc_x = {5'b00000, accum_reg};

    always_comb
    begin
        case (rad_eff)
            ils_pkg::RX_HEX: prod = acc_x << 4;
            ils_pkg::RX_BIN: prod = acc_x << 1;
            ils_pkg::RX_OCT: prod = acc_x << 3;
            default:         prod = (acc_x << 3) + (acc_x << 1);
        endcase
    end

    assign sum = prod + XW'(dig_eff);
    assign ovf = |sum[XW-1:VALUE_WIDTH];

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        accum_next = accum_reg;
        bad_next   = bad_reg;
        emit       = 1'b0;
        ovf_out    = 1'b0;

        case (phase_reg)
            ils_pkg::PH_START:
            begin
                if (ch == ils_pkg::CH_0)
                begin
                    accum_next = '0;
                    phase_next = ils_pkg::PH_ZERO;
                end
                else if (ch_dec)
                begin
                    if (ovf)
                    begin
                        accum_next = '0;
                        phase_next = ils_pkg::PH_SWALLOW;
                    end
                    else
                    begin
                        accum_next = sum[VALUE_WIDTH-1:0];
                        phase_next = ils_pkg::PH_DIGITS;
                    end
                end
            end
            ils_pkg::PH_SWALLOW:
            begin
                if (!ch_dec)
                begin
                    emit    = 1'b1;
                    ovf_out = 1'b1;
                end
            end
            default:
            begin
                if ((phase_reg == ils_pkg::PH_ZERO) &&
                    ((ch == ils_pkg::CH_LX) || (ch == ils_pkg::CH_UX)))
                begin
                    radix_next = ils_pkg::RX_HEX;
                    phase_next = ils_pkg::PH_DIGITS;
                end
                else if ((phase_reg == ils_pkg::PH_ZERO) &&
                         ((ch == ils_pkg::CH_LB) || (ch == ils_pkg::CH_UB)))
                begin
                    radix_next = ils_pkg::RX_BIN;
                    phase_next = ils_pkg::PH_DIGITS;
                end
                else if (dig == ils_pkg::NO_DIGIT)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    radix_next = rad_eff;
                    bad_next   = bad_take;
                    if (ovf)
                    begin
                        accum_next = '0;
                        if (ch_dec)
                            phase_next = ils_pkg::PH_SWALLOW;
                        else
                        begin
                            emit    = 1'b1;
                            ovf_out = 1'b1;
                        end
                    end
                    else
                    begin
                        accum_next = sum[VALUE_WIDTH-1:0];
                        phase_next = ils_pkg::PH_DIGITS;
                    end
                end
            end
        endcase

        // Return to the start of a literal once a result goes out.
        if (emit)
        begin
            phase_next = ils_pkg::PH_START;
            radix_next = ils_pkg::RX_DEC;
            accum_next = '0;
            bad_next   = 1'b0;
        end
    end

    // Overflow always reports a zero value; otherwise the stored value.
    assign res.value     = ovf_out ? '0 : ils_pkg::DATA_W'(accum_reg);
    assign res.radix     = rad_eff;
    // A hex letter that overflows is itself a digit; a terminator after
    // swallowed digits is not.
    assign res.bad_digit = (ovf_out && (phase_reg != ils_pkg::PH_SWALLOW)) ? bad_take
                                                                            : bad_reg;
    assign res.overflow  = ovf_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ils_pkg::PH_START;
            radix_reg <= ils_pkg::RX_DEC;
            accum_reg <= '0;
            bad_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            accum_reg <= accum_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

`default_nettype wire

### hdl/ils_out_reg.sv
// ----------------------------------------------------------------------------
// ils_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_out_reg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire ils_pkg::res_t                res,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [ils_pkg::DATA_W-1:0]        m_tdata,  // [63:0] value
    output logic [ils_pkg::USER_W-1:0]        m_tuser   // [1:0] radix, [2] bad_digit,
                                                        // [3] overflow
);

    logic          valid_reg;
    logic          valid_next;
    ils_pkg::res_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.value;
    assign m_tuser  = {res_reg.overflow, res_reg.bad_digit, res_reg.radix};

endmodule

`default_nettype wire

### hdl/integer_literal_scanner_unit.sv
// ----------------------------------------------------------------------------
// integer_literal_scanner_unit
// Scans integer literals with 0x / 0b / leading-zero octal prefixes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one source character per item in s_tdata[7:0].
//   Master channel: one result item per literal, sent when the first
//   character outside the literal arrives or a hex letter overflows (that
//   character is dropped after ending the literal). m_tdata carries the
//   value, zero-extended to 64 bits; m_tuser carries radix, bad_digit and
//   overflow. Bytes that are not digits outside a literal produce no result.
// Timing:
//   One character per cycle while no terminator stalls. A character waits in
//   the input register while the core decodes it against the scanner state;
//   a result is loaded into the output register as its terminator is consumed.
// Reset and stall:
//   rst_n clears the scanner and empties both registers. While a result waits
//   on m_tready, characters that do not end a literal keep flowing; a
//   terminator holds in the input register and s_tready drops until the
//   result is taken.
`default_nettype none

module integer_literal_scanner_unit #(
    parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] ch
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [ils_pkg::DATA_W-1:0]        m_tdata,   // [63:0] value
    output logic [ils_pkg::USER_W-1:0]        m_tuser    // [1:0] radix, [2] bad_digit,
                                                         // [3] overflow
);

    logic          ch_valid;
    logic [7:0]    ch;
    logic          advance;
    logic          emit;
    ils_pkg::res_t res;

    // Advance unless this item ends a literal while the result slot is full.
    assign advance = ch_valid && (!emit || !m_tvalid || m_tready);

    ils_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .consume  (advance),
        .ch_valid (ch_valid),
        .ch       (ch)
    );

    ils_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ch      (ch),
        .advance (advance),
        .emit    (emit),
        .res     (res)
    );

    ils_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && emit),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> m_tdata == '0)
        else $error("overflow result with nonzero value");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >> VALUE_WIDTH) == '0)
        else $error("result value exceeds configured width");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> m_tvalid)
        else $error("ended literal did not produce a result");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid && !advance |=> ch_valid && $stable(ch))
        else $error("pending character lost while stalled");
`endif

endmodule

`default_nettype wire
